>>> rtl/ecal_pkg.sv
// Shared types, constants and helper functions for the epoch-to-calendar converter.
package ecal_pkg;

    // Time and calendar constants
    localparam int unsigned SECS_PER_DAY   = 24 * 60 * 60;
    localparam int unsigned DAYS_PER_CYCLE = 146097;
    localparam int unsigned SECS_PER_HOUR  = 3600;
    localparam int unsigned SECS_PER_MIN   = 60;
    localparam int unsigned HOURS_HALF     = 12;
    localparam int unsigned EPOCH_YEAR     = 1970;
    localparam int unsigned YEARS_PER_CYCLE = 400;
    localparam int unsigned EPOCH_MOD400   = EPOCH_YEAR % YEARS_PER_CYCLE;
    localparam int unsigned DAYS_LEAP      = 366;
    localparam int unsigned DAYS_NORMAL    = 365;
    localparam int unsigned LAST_MONTH_IDX = 11;

    // Internal widths
    localparam int unsigned REM_W   = 18;   // holds any remainder below 146097
    localparam int unsigned TOD_W   = 17;   // second of day, below 86400
    localparam int unsigned YEAR_W  = 12;
    localparam int unsigned YMOD_W  = 9;    // year modulo 400
    localparam int unsigned YLEN_W  = 9;
    localparam int unsigned MON_W   = 4;
    localparam int unsigned MLEN_W  = 5;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned CYC_MUL_W = YEAR_W + YMOD_W;

    // Chunked reciprocal divide: partial dividend is remainder and one chunk
    localparam int unsigned CHUNK_W   = 16;
    localparam int unsigned PART_W    = REM_W + CHUNK_W;
    localparam int unsigned RCP_SHIFT = 34;
    localparam int unsigned RCP_W     = 18;
    localparam int unsigned RCP_DAY   = 198841;   // floor(2^34 / 86400)
    localparam int unsigned RCP_CYCLE = 117592;   // floor(2^34 / 146097)

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_DAY,
        ST_XFER,
        ST_DIV_CYCLE,
        ST_YEAR_INIT,
        ST_YEAR_WALK,
        ST_MONTH_WALK,
        ST_FINISH
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_in;
        logic div_step;
        logic div_sel_cycle;
        logic div_to_cycle;
        logic year_init;
        logic year_step;
        logic month_step;
        logic tod_step;
        logic out_load;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic div_last;
        logic year_fit;
        logic month_fit;
        logic tod_done;
    } status_t;

    // Days in a month, month index 0 is January
    function automatic logic [MLEN_W-1:0] month_len(input logic [MON_W-1:0] idx,
                                                    input logic leap);
        logic [MLEN_W-1:0] len;
        case (idx)
            4'd1:                   len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

    // Gregorian leap rule on the year modulo 400
    function automatic logic is_leap(input logic [YMOD_W-1:0] ymod);
        return (ymod == '0) ||
               ((ymod[1:0] == 2'd0) && (ymod != 9'd100) && (ymod != 9'd200) &&
                (ymod != 9'd300));
    endfunction

endpackage

>>> rtl/ecal_dp.sv
// Datapath: reciprocal divider, year and month walk, time-of-day walk, output registers.
module ecal_dp #(
    parameter int SECONDS_WIDTH = 32
) (
    input  logic                          clk,
    input  logic [SECONDS_WIDTH-1:0]      seconds_since_epoch,
    input  ecal_pkg::cmd_t                cmd,
    output ecal_pkg::status_t             status,
    output logic [11:0]                   year,
    output logic [3:0]                    month,
    output logic [4:0]                    day_of_month,
    output logic [4:0]                    hour_of_day,
    output logic [3:0]                    hour_twelve,
    output logic                          is_pm,
    output logic [5:0]                    minute,
    output logic [5:0]                    second
);

    // Dividend is handled in 16-bit chunks, top chunk first
    localparam int NCH    = (SECONDS_WIDTH + ecal_pkg::CHUNK_W - 1) / ecal_pkg::CHUNK_W;
    localparam int DVD_W  = NCH * ecal_pkg::CHUNK_W;
    localparam int CNT_W  = $clog2(NCH);
    localparam int PROD_W = ecal_pkg::PART_W + ecal_pkg::RCP_W;

    // Divider state
    logic [DVD_W-1:0]              dvd_reg, dvd_next;
    logic [ecal_pkg::REM_W-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic                          fix_reg, fix_next;    // estimate held, correct next
    logic [ecal_pkg::CHUNK_W-1:0]  qest_reg, qest_next;

    // Calendar walk state
    logic [ecal_pkg::REM_W-1:0]  day_reg, day_next;
    logic [ecal_pkg::YEAR_W-1:0] year_reg, year_next;
    logic [ecal_pkg::YMOD_W-1:0] ymod_reg, ymod_next;
    logic [ecal_pkg::MON_W-1:0]  mon_reg, mon_next;

    // Time-of-day walk state
    logic [ecal_pkg::TOD_W-1:0]  tod_reg, tod_next;
    logic [ecal_pkg::HOUR_W-1:0] hour_reg, hour_next;
    logic [ecal_pkg::MIN_W-1:0]  min_reg, min_next;

    // Output registers
    logic [11:0] year_out_reg;
    logic [3:0]  month_out_reg;
    logic [4:0]  day_out_reg;
    logic [4:0]  hour_out_reg;
    logic [3:0]  hour12_out_reg;
    logic        pm_out_reg;
    logic [5:0]  min_out_reg;
    logic [5:0]  sec_out_reg;

    logic [ecal_pkg::REM_W-1:0]   divisor;
    logic [ecal_pkg::RCP_W-1:0]   recip;
    logic [ecal_pkg::PART_W-1:0]  div_part;
    logic [PROD_W-1:0]            part_prod;
    logic [ecal_pkg::PART_W-1:0]  back_prod;
    logic [ecal_pkg::PART_W-1:0]  part_rem;
    logic [ecal_pkg::PART_W-1:0]  part_over;
    logic                         rem_over;
    logic [ecal_pkg::CHUNK_W-1:0] qdig;
    logic                         leap;
    logic [ecal_pkg::YLEN_W-1:0]  ylen;
    logic [ecal_pkg::MLEN_W-1:0]  mlen;
    logic [ecal_pkg::CYC_MUL_W-1:0] cyc_years;
    logic                         tod_ge_hour;
    logic                         tod_ge_min;
    logic                         pm;
    logic [ecal_pkg::HOUR_W-1:0]  hour_mod12;

    // Reciprocal divide of one chunk: the estimate is low by at most one
    always_comb
    begin
        divisor   = cmd.div_sel_cycle ? ecal_pkg::REM_W'(ecal_pkg::DAYS_PER_CYCLE)
                                      : ecal_pkg::REM_W'(ecal_pkg::SECS_PER_DAY);
        recip     = cmd.div_sel_cycle ? ecal_pkg::RCP_W'(ecal_pkg::RCP_CYCLE)
                                      : ecal_pkg::RCP_W'(ecal_pkg::RCP_DAY);
        div_part  = {rem_reg, dvd_reg[DVD_W-1 -: ecal_pkg::CHUNK_W]};
        // 34 x 18 bits
        part_prod = PROD_W'(div_part) * PROD_W'(recip);
        // 16 x 18 bits
        back_prod = ecal_pkg::PART_W'(qest_reg) * ecal_pkg::PART_W'(divisor);
        part_rem  = div_part - back_prod;
        part_over = part_rem - ecal_pkg::PART_W'(divisor);
        rem_over  = part_rem >= ecal_pkg::PART_W'(divisor);
        qdig      = rem_over ? qest_reg + 1'b1 : qest_reg;
    end

    // Year and month lengths, cycle years and time-of-day compares
    always_comb
    begin
        leap = ecal_pkg::is_leap(ymod_reg);
        ylen = leap ? ecal_pkg::YLEN_W'(ecal_pkg::DAYS_LEAP)
                    : ecal_pkg::YLEN_W'(ecal_pkg::DAYS_NORMAL);
        mlen = ecal_pkg::month_len(mon_reg, leap);
        cyc_years = ecal_pkg::CYC_MUL_W'(dvd_reg[ecal_pkg::YEAR_W-1:0]) *
                    ecal_pkg::CYC_MUL_W'(ecal_pkg::YEARS_PER_CYCLE);
        tod_ge_hour = tod_reg >= ecal_pkg::TOD_W'(ecal_pkg::SECS_PER_HOUR);
        tod_ge_min  = tod_reg >= ecal_pkg::TOD_W'(ecal_pkg::SECS_PER_MIN);
    end

    // Status to controller
    always_comb
    begin
        status.div_last  = (cnt_reg == CNT_W'(NCH - 1)) && fix_reg;
        status.year_fit  = day_reg < ecal_pkg::REM_W'(ylen);
        status.month_fit = (mon_reg == ecal_pkg::MON_W'(ecal_pkg::LAST_MONTH_IDX)) ||
                           (day_reg < ecal_pkg::REM_W'(mlen));
        status.tod_done  = !tod_ge_min;
    end

    // Next-state logic
    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        fix_next  = fix_reg;
        qest_next = qest_reg;
        day_next  = day_reg;
        year_next = year_reg;
        ymod_next = ymod_reg;
        mon_next  = mon_reg;
        tod_next  = tod_reg;
        hour_next = hour_reg;
        min_next  = min_reg;

        if (cmd.load_in)
        begin
            dvd_next = DVD_W'(seconds_since_epoch);
            rem_next = '0;
            cnt_next = '0;
            fix_next = 1'b0;
        end
        else if (cmd.div_step)
        begin
            if (!fix_reg)
            begin
                // quotient digit estimate
                qest_next = part_prod[ecal_pkg::RCP_SHIFT +: ecal_pkg::CHUNK_W];
                fix_next  = 1'b1;
            end
            else
            begin
                // corrected digit shifts in, next chunk moves to the top
                dvd_next = {dvd_reg[DVD_W-ecal_pkg::CHUNK_W-1:0], qdig};
                rem_next = rem_over ? ecal_pkg::REM_W'(part_over)
                                    : ecal_pkg::REM_W'(part_rem);
                cnt_next = cnt_reg + 1'b1;
                fix_next = 1'b0;
            end
        end
        else if (cmd.div_to_cycle)
        begin
            // quotient in dvd is now the day count
            rem_next  = '0;
            cnt_next  = '0;
            fix_next  = 1'b0;
            tod_next  = rem_reg[ecal_pkg::TOD_W-1:0];
            hour_next = '0;
            min_next  = '0;
        end

        // Start year walk at 1970 plus whole 400-year cycles
        if (cmd.year_init)
        begin
            day_next  = rem_reg;
            year_next = ecal_pkg::YEAR_W'(ecal_pkg::EPOCH_YEAR) +
                        cyc_years[ecal_pkg::YEAR_W-1:0];
            ymod_next = ecal_pkg::YMOD_W'(ecal_pkg::EPOCH_MOD400);
            mon_next  = '0;
        end
        else if (cmd.year_step && !status.year_fit)
        begin
            day_next  = day_reg - ecal_pkg::REM_W'(ylen);
            year_next = year_reg + 1'b1;
            ymod_next = (ymod_reg == ecal_pkg::YMOD_W'(ecal_pkg::YEARS_PER_CYCLE - 1))
                        ? '0 : ymod_reg + 1'b1;
        end
        else if (cmd.month_step && !status.month_fit)
        begin
            day_next = day_reg - ecal_pkg::REM_W'(mlen);
            mon_next = mon_reg + 1'b1;
        end

        // Hours first, then minutes, leaving seconds
        if (cmd.tod_step)
        begin
            if (tod_ge_hour)
            begin
                tod_next  = tod_reg - ecal_pkg::TOD_W'(ecal_pkg::SECS_PER_HOUR);
                hour_next = hour_reg + 1'b1;
            end
            else if (tod_ge_min)
            begin
                tod_next = tod_reg - ecal_pkg::TOD_W'(ecal_pkg::SECS_PER_MIN);
                min_next = min_reg + 1'b1;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        fix_reg  <= fix_next;
        qest_reg <= qest_next;
        day_reg  <= day_next;
        year_reg <= year_next;
        ymod_reg <= ymod_next;
        mon_reg  <= mon_next;
        tod_reg  <= tod_next;
        hour_reg <= hour_next;
        min_reg  <= min_next;
    end

    // 12-hour form
    always_comb
    begin
        pm         = hour_reg >= ecal_pkg::HOUR_W'(ecal_pkg::HOURS_HALF);
        hour_mod12 = pm ? hour_reg - ecal_pkg::HOUR_W'(ecal_pkg::HOURS_HALF) : hour_reg;
    end

    // Result registers
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            year_out_reg   <= year_reg;
            month_out_reg  <= mon_reg + 1'b1;
            day_out_reg    <= day_reg[4:0] + 1'b1;
            hour_out_reg   <= hour_reg;
            hour12_out_reg <= (hour_mod12 == '0) ? 4'(ecal_pkg::HOURS_HALF)
                                                 : hour_mod12[3:0];
            pm_out_reg     <= pm;
            min_out_reg    <= min_reg;
            sec_out_reg    <= tod_reg[5:0];
        end
    end

    assign year         = year_out_reg;
    assign month        = month_out_reg;
    assign day_of_month = day_out_reg;
    assign hour_of_day  = hour_out_reg;
    assign hour_twelve  = hour12_out_reg;
    assign is_pm        = pm_out_reg;
    assign minute       = min_out_reg;
    assign second       = sec_out_reg;

endmodule

>>> rtl/ecal_ctrl.sv
// Controller: sequences division, year walk, month walk and result hand-off.
module ecal_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  ecal_pkg::status_t  status,
    output ecal_pkg::cmd_t     cmd
);

    ecal_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    // State and result-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ecal_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            ecal_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ecal_pkg::ST_DIV_DAY;
                end
            end
            ecal_pkg::ST_DIV_DAY:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = ecal_pkg::ST_XFER;
            end
            ecal_pkg::ST_XFER:
            begin
                cmd.div_to_cycle = 1'b1;
                state_next       = ecal_pkg::ST_DIV_CYCLE;
            end
            ecal_pkg::ST_DIV_CYCLE:
            begin
                cmd.div_step      = 1'b1;
                cmd.div_sel_cycle = 1'b1;
                cmd.tod_step      = 1'b1;
                if (status.div_last)
                    state_next = ecal_pkg::ST_YEAR_INIT;
            end
            ecal_pkg::ST_YEAR_INIT:
            begin
                cmd.year_init = 1'b1;
                cmd.tod_step  = 1'b1;
                state_next    = ecal_pkg::ST_YEAR_WALK;
            end
            ecal_pkg::ST_YEAR_WALK:
            begin
                cmd.year_step = 1'b1;
                cmd.tod_step  = 1'b1;
                if (status.year_fit)
                    state_next = ecal_pkg::ST_MONTH_WALK;
            end
            ecal_pkg::ST_MONTH_WALK:
            begin
                cmd.month_step = 1'b1;
                cmd.tod_step   = 1'b1;
                if (status.month_fit)
                    state_next = ecal_pkg::ST_FINISH;
            end
            ecal_pkg::ST_FINISH:
            begin
                cmd.tod_step = 1'b1;
                // hand off once time of day is split and the result slot is free
                if (status.tod_done && (!out_valid_reg || out_ready))
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ecal_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ecal_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

>>> rtl/epoch_seconds_to_calendar.sv
// Top level of the epoch-seconds to Gregorian date and time converter.
// Converts seconds since 1970-01-01 00:00:00 into year, month, day, 24-hour and
// 12-hour time with a PM flag, minute and second; one result per item. A shared
// divider works through its dividend 16 bits at a time with a reciprocal multiply
// and one correction for each chunk: it first splits off the day count and then
// whole 400-year cycles, after which years and months are subtracted one per
// cycle. The year walk passes up to 136 years past the last whole 400-year cycle
// for 32-bit input, up to 399 in general, and the month walk up to 11 months.
// Hours and then minutes are subtracted one per cycle alongside, starting with
// the cycle division, in a walk of up to 82 steps; the result is loaded once both
// walks are done and the result slot is free. A new item is taken only when the
// converter is idle, after the last result is loaded. The finished result sits in
// an output register, so the next item is taken while it waits.
module epoch_seconds_to_calendar #(
    parameter int SECONDS_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [SECONDS_WIDTH-1:0] seconds_since_epoch,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [11:0]              year,
    output logic [3:0]               month,
    output logic [4:0]               day_of_month,
    output logic [4:0]               hour_of_day,
    output logic [3:0]               hour_twelve,
    output logic                     is_pm,
    output logic [5:0]               minute,
    output logic [5:0]               second
);

    ecal_pkg::cmd_t    cmd;
    ecal_pkg::status_t status;

    // Sequencer
    ecal_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Arithmetic and result registers
    ecal_dp #(
        .SECONDS_WIDTH (SECONDS_WIDTH)
    ) u_dp (
        .clk                 (clk),
        .seconds_since_epoch (seconds_since_epoch),
        .cmd                 (cmd),
        .status              (status),
        .year                (year),
        .month               (month),
        .day_of_month        (day_of_month),
        .hour_of_day         (hour_of_day),
        .hour_twelve         (hour_twelve),
        .is_pm               (is_pm),
        .minute              (minute),
        .second              (second)
    );

endmodule
